// ----- hw/rtl/aip_pkg.sv -----
package aip_pkg;

	// counter width for consumed characters (4..32)
	localparam int COUNT_BITS = 16;
	localparam int CONSUMED_BITS = 16;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	// config register indexes
	localparam logic CFG_BASE_SELECT = 1'b0;
	localparam logic CFG_SIGNED_MODE = 1'b1;
	localparam int CFG_DATA_BITS = 5;

	// characters of interest
	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] CH_LO_A = 8'h61;
	localparam logic [7:0] CH_LO_F = 8'h66;
	localparam logic [7:0] CH_UP_A = 8'h41;
	localparam logic [7:0] CH_UP_F = 8'h46;
	localparam logic [7:0] CH_X = 8'h78;
	localparam logic [7:0] CH_MINUS = 8'h2d;

	// bases
	localparam logic [4:0] BASE_AUTO = 5'd0;
	localparam logic [4:0] BASE_DEC = 5'd10;
	localparam logic [4:0] BASE_HEX = 5'd16;

	typedef enum logic [5:0] {
		PH_IDLE   = 6'b000001,
		PH_PREFIX = 6'b000010,
		PH_ZERO   = 6'b000100,
		PH_AUTO0  = 6'b001000,
		PH_AUTO0X = 6'b010000,
		PH_DIGITS = 6'b100000
	} aip_phase_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       first;
	} aip_in_t;

	typedef struct packed {
		logic [63:0]              value;
		logic [CONSUMED_BITS-1:0] consumed;
	} aip_out_t;

	typedef struct packed {
		logic [4:0] base_select;
		logic       signed_mode;
	} aip_cfg_t;

	typedef struct packed {
		aip_phase_t            phase;
		logic                  neg;
		logic [63:0]           acc;
		logic [COUNT_BITS-1:0] cnt;
		logic [4:0]            base;
	} aip_state_t;

	// saturating count step
	function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
		logic [COUNT_BITS-1:0] r;
		r = (c == COUNT_MAX) ? c : c + COUNT_BITS'(1);
		return r;
	endfunction

endpackage

// ----- hw/rtl/aip_core.sv -----
module aip_core import aip_pkg::*; (
	input  aip_state_t st,
	input  aip_in_t    item,
	input  aip_cfg_t   cfg,
	output aip_state_t nxt,
	output logic       emit,
	output aip_out_t   res
);

	aip_state_t  w;
	logic        want_prefix;
	logic        want_digit;
	logic        is_dec;
	logic        is_lo;
	logic        is_up;
	logic [3:0]  dval;
	logic [63:0] prod;
	logic [31:0] cnt_ext;

	// one character through the parse
	always_comb begin
		w = st;
		want_prefix = 1'b0;
		want_digit = 1'b0;
		emit = 1'b0;
		is_dec = 1'b0;
		is_lo = 1'b0;
		is_up = 1'b0;
		dval = 4'd0;
		prod = 64'd0;

		if (item.first) begin
			w.neg = 1'b0;
			w.acc = 64'd0;
			w.cnt = '0;
			if (cfg.base_select == BASE_AUTO && item.ch == CH_ZERO) begin
				w.base = BASE_DEC;
				w.cnt = COUNT_BITS'(1);
				w.phase = PH_AUTO0;
			end else begin
				w.base = (cfg.base_select == BASE_AUTO) ? BASE_DEC : cfg.base_select;
				if (cfg.signed_mode && item.ch == CH_MINUS) begin
					w.neg = 1'b1;
					w.cnt = COUNT_BITS'(1);
					w.phase = PH_PREFIX;
				end else begin
					want_prefix = 1'b1;
				end
			end
		end else begin
			unique case (st.phase)
				PH_PREFIX: want_prefix = 1'b1;
				PH_ZERO: begin
					if (item.ch == CH_X) begin
						w.cnt = sat_inc(st.cnt);
						w.phase = PH_DIGITS;
					end else begin
						want_digit = 1'b1;
					end
				end
				PH_AUTO0: begin
					if (item.ch == CH_X) begin
						w.phase = PH_AUTO0X;
					end else begin
						w.base = BASE_DEC;
						want_digit = 1'b1;
					end
				end
				PH_AUTO0X: begin
					if (item.ch == CH_NUL) begin
						w.base = BASE_DEC;
						emit = 1'b1;
					end else begin
						// "0x" confirmed: hex, prefix counted
						w.base = BASE_HEX;
						w.cnt = COUNT_BITS'(2);
						want_digit = 1'b1;
					end
				end
				PH_DIGITS: want_digit = 1'b1;
				default: ;
			endcase
		end

		// optional 0x prefix in hex
		if (want_prefix) begin
			if (w.base == BASE_HEX && item.ch == CH_ZERO) begin
				w.cnt = sat_inc(w.cnt);
				w.phase = PH_ZERO;
			end else begin
				want_digit = 1'b1;
			end
		end

		// digit decode and multiply-add
		is_dec = (item.ch >= CH_ZERO) && (item.ch <= CH_NINE);
		is_lo = (w.base == BASE_HEX) && (item.ch >= CH_LO_A) && (item.ch <= CH_LO_F);
		is_up = (w.base == BASE_HEX) && (item.ch >= CH_UP_A) && (item.ch <= CH_UP_F);
		if (is_dec)
			dval = 4'(item.ch - CH_ZERO);
		else if (is_lo)
			dval = 4'(item.ch - CH_LO_A + 8'd10);
		else
			dval = 4'(item.ch - CH_UP_A + 8'd10);
		prod = w.acc * {59'd0, w.base};

		if (want_digit) begin
			if (is_dec || is_lo || is_up) begin
				w.acc = prod + {60'd0, dval};
				w.cnt = sat_inc(w.cnt);
				w.phase = PH_DIGITS;
			end else begin
				emit = 1'b1;
			end
		end

		if (emit)
			w.phase = PH_IDLE;
	end

	assign nxt = w;

	// result fields, taken from the next parse state
	assign cnt_ext = 32'(w.cnt);
	assign res.value = w.neg ? (64'd0 - w.acc) : w.acc;
	assign res.consumed = (cnt_ext > 32'(16'hFFFF)) ? 16'hFFFF : cnt_ext[CONSUMED_BITS-1:0];

endmodule

// ----- hw/rtl/aip_out.sv -----
module aip_out import aip_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     load,
	input  aip_out_t din,
	output logic     free,
	output logic     result_valid,
	input  logic     result_stall,
	output aip_out_t result
);

	logic     valid_q;
	aip_out_t data_q;

	// slot can take a beat when empty or being drained
	assign free = !valid_q || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			data_q <= din;
		end
	end

	assign result_valid = valid_q;
	assign result = data_q;

endmodule

// ----- hw/rtl/ascii_integer_parser.sv -----
// Channel | Signals                          | Beat
// --------+----------------------------------+-------------------------------
// item    | item_valid, item_stall, item     | one character and first flag
// result  | result_valid, result_stall, result | parsed value and consumed count
// config  | cfg_we, cfg_index, cfg_data      | register write, no read-back
//
// One character per cycle sustained unless a stalled result holds a character.
// A character is registered, then the parse step (multiply-add by the base)
// updates the state and the result register.
// Reset clears the parse state and sets base_select = 0, signed_mode = 1.
// A stalled result blocks only a character that ends a string; others pass.
module ascii_integer_parser import aip_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     item_valid,
	output logic                     item_stall,
	input  aip_in_t                  item,
	output logic                     result_valid,
	input  logic                     result_stall,
	output aip_out_t                 result,
	input  logic                     cfg_we,
	input  logic                     cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data
);

	aip_cfg_t   cfg_q;
	aip_state_t st_q;
	aip_state_t st_nxt;
	aip_in_t    item_s1;
	logic       valid_s1;
	logic       emit;
	aip_out_t   res;
	logic       out_free;
	logic       advance;
	logic       take;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.base_select <= BASE_AUTO;
			cfg_q.signed_mode <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_BASE_SELECT: cfg_q.base_select <= cfg_data[4:0];
				CFG_SIGNED_MODE: cfg_q.signed_mode <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// parse step moves on unless its result has nowhere to go
	assign advance = valid_s1 && (!emit || out_free);
	assign item_stall = valid_s1 && !advance;
	assign take = item_valid && !item_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= item;
		end
	end

	aip_core u_core (
		.st   (st_q),
		.item (item_s1),
		.cfg  (cfg_q),
		.nxt  (st_nxt),
		.emit (emit),
		.res  (res)
	);

	// parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.phase <= PH_IDLE;
			st_q.neg <= 1'b0;
			st_q.acc <= 64'd0;
			st_q.cnt <= '0;
			st_q.base <= BASE_DEC;
		end else if (advance) begin
			st_q <= st_nxt;
		end
	end

	aip_out u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (advance && emit),
		.din          (res),
		.free         (out_free),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

`ifndef SYNTHESIS
	// a held character keeps its beat until it can finish
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(item_s1)))
		else $error("held character lost or changed");

	// a finished string leaves the parser idle
	a_emit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && emit) |=> (st_q.phase == PH_IDLE))
		else $error("parser not idle after result");

	// within a string the count never drops
	a_cnt_mono: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !item_s1.first) |=> (st_q.cnt >= $past(st_q.cnt)))
		else $error("consumed count decreased");

	// a result is loaded only into a free slot
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && emit && result_valid && result_stall) |-> 1'b0)
		else $error("result overwritten while stalled");
`endif

endmodule

// ----- sim/tb_ascii_integer_parser.sv -----
module tb_ascii_integer_parser;
	import aip_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_PERIOD = 10;
	localparam int RESET_CYCLES = 6;
	localparam int SETTLE_CYCLES = 6;
	localparam int HOLD_CYCLES = 300;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam logic [4:0] BASE_MAX = 5'd31;

	// Running parse of the character stream; queues the value/count pairs it predicts.
	class parse_scoreboard;
		logic [4:0]            base_sel;
		logic                  sign_en;
		aip_phase_t            phase;
		logic                  neg;
		logic [63:0]           acc;
		logic [COUNT_BITS-1:0] cnt;
		logic [4:0]            base;
		aip_out_t              pending[$];
		int                    errors;

		function new();
			errors = 0;
			base_sel = BASE_AUTO;
			sign_en = 1'b1;
			phase = PH_IDLE;
			neg = 1'b0;
			acc = '0;
			cnt = '0;
			base = BASE_DEC;
		endfunction

		function void write_cfg(input logic idx, input logic [CFG_DATA_BITS-1:0] d);
			if (idx == CFG_BASE_SELECT) begin
				base_sel = d;
			end else begin
				sign_en = d[0];
			end
		endfunction

		function void count_up();
			if (cnt != COUNT_MAX) begin
				cnt = cnt + COUNT_BITS'(1);
			end
		endfunction

		// string ends here: queue the value and the clipped count
		function void close_parse();
			aip_out_t r;
			r.value = neg ? -acc : acc;
			r.consumed = (64'(cnt) > 64'({CONSUMED_BITS{1'b1}})) ? '1 : CONSUMED_BITS'(cnt);
			pending.push_back(r);
			phase = PH_IDLE;
		endfunction

		function void take_digit(input logic [7:0] c);
			logic [63:0] dv;
			if (c >= CH_ZERO && c <= CH_NINE) begin
				dv = 64'(c - CH_ZERO);
			end else if (base == BASE_HEX && c >= CH_LO_A && c <= CH_LO_F) begin
				dv = 64'(c - CH_LO_A) + 64'd10;
			end else if (base == BASE_HEX && c >= CH_UP_A && c <= CH_UP_F) begin
				dv = 64'(c - CH_UP_A) + 64'd10;
			end else begin
				close_parse();
				return;
			end
			acc = acc * 64'(base) + dv;
			count_up();
			phase = PH_DIGITS;
		endfunction

		// right after the optional sign: hex may open with a zero of the prefix
		function void take_prefix(input logic [7:0] c);
			if (base == BASE_HEX && c == CH_ZERO) begin
				count_up();
				phase = PH_ZERO;
			end else begin
				take_digit(c);
			end
		endfunction

		function void note_item(input aip_in_t it);
			if (it.first) begin
				neg = 1'b0;
				acc = '0;
				cnt = '0;
				// auto base: a leading zero may open a hex prefix
				if (base_sel == BASE_AUTO && it.ch == CH_ZERO) begin
					base = BASE_DEC;
					cnt = COUNT_BITS'(1);
					phase = PH_AUTO0;
					return;
				end
				base = (base_sel == BASE_AUTO) ? BASE_DEC : base_sel;
				if (sign_en && it.ch == CH_MINUS) begin
					neg = 1'b1;
					cnt = COUNT_BITS'(1);
					phase = PH_PREFIX;
					return;
				end
				take_prefix(it.ch);
				return;
			end
			case (phase)
				PH_PREFIX: take_prefix(it.ch);
				PH_ZERO: begin
					if (it.ch == CH_X) begin
						count_up();
						phase = PH_DIGITS;
					end else begin
						take_digit(it.ch);
					end
				end
				PH_AUTO0: begin
					if (it.ch == CH_X) begin
						phase = PH_AUTO0X;
					end else begin
						base = BASE_DEC;
						take_digit(it.ch);
					end
				end
				PH_AUTO0X: begin
					// "0x" then NUL stays decimal with only the zero taken
					if (it.ch == CH_NUL) begin
						base = BASE_DEC;
						close_parse();
					end else begin
						base = BASE_HEX;
						cnt = (COUNT_MAX < COUNT_BITS'(2)) ? COUNT_MAX : COUNT_BITS'(2);
						take_digit(it.ch);
					end
				end
				PH_DIGITS: take_digit(it.ch);
				default: ;
			endcase
		endfunction

		task report(input string msg);
			$display("%0t ns  error: %s", $time, msg);
			errors++;
		endtask

		task check_result(input aip_out_t got);
			aip_out_t want;
			if (pending.size() == 0) begin
				report($sformatf("result with none outstanding: value %h consumed %0d",
					got.value, got.consumed));
				return;
			end
			want = pending.pop_front();
			if (got.value !== want.value) begin
				report($sformatf("value %h, wanted %h", got.value, want.value));
			end
			if (got.consumed !== want.consumed) begin
				report($sformatf("consumed %0d, wanted %0d", got.consumed, want.consumed));
			end
		endtask
	endclass

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     item_valid = 1'b0;
	logic                     item_stall;
	aip_in_t                  item = '0;
	logic                     result_valid;
	logic                     result_stall = 1'b0;
	aip_out_t                 result;
	logic                     cfg_we = 1'b0;
	logic                     cfg_index = 1'b0;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;

	parse_scoreboard sb = new();
	bit tx_gaps = 1'b1;
	bit rx_gaps = 1'b1;
	bit hold_req = 1'b0;
	int quiet_cycles = 0;

	ascii_integer_parser DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// beat monitor and watchdog on cycles with no beat on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && !item_stall) begin
				sb.note_item(item);
			end
			if (result_valid && !result_stall) begin
				sb.check_result(result);
			end
			if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= WATCHDOG_LIMIT) begin
					$display("SCOREBOARD MISMATCH");
					$finish;
				end
			end
		end
	end

	// result side: random stall bursts, plus one long hold-off on request
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				result_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				result_stall <= 1'b0;
			end else if (rx_gaps && $urandom_range(0, 7) == 0) begin
				result_stall <= 1'b1;
				repeat ($urandom_range(1, 14)) @(posedge clk);
				result_stall <= 1'b0;
			end
		end
	end

	// one character beat, with an occasional idle burst ahead of it
	task automatic put(input logic [7:0] c, input logic f);
		aip_in_t beat;
		beat.ch = c;
		beat.first = f;
		if (tx_gaps && $urandom_range(0, 7) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= beat;
		@(posedge clk);
		while (item_stall) @(posedge clk);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) begin
			put(s[i], i == 0);
		end
	endtask

	// stop sending and wait until every predicted result is back
	task automatic settle();
		item_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [CFG_DATA_BITS-1:0] d);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		sb.write_cfg(idx, d);
		cfg_we <= 1'b0;
	endtask

	// spare upper data bits go random on the one-bit register
	task automatic set_mode(input logic [4:0] b, input logic sgn);
		settle();
		write_reg(CFG_BASE_SELECT, b);
		write_reg(CFG_SIGNED_MODE, {4'($urandom_range(0, 15)), sgn});
	endtask

	function automatic logic [7:0] rand_digit(input bit hex);
		int r;
		r = $urandom_range(0, hex ? 21 : 9);
		if (r < 10) begin
			return CH_ZERO + 8'(r);
		end else if (r < 16) begin
			return CH_LO_A + 8'(r - 10);
		end
		return CH_UP_A + 8'(r - 16);
	endfunction

	// mostly well-formed numbers, some left open, the rest noise
	task automatic random_string(output int n);
		logic [7:0] s[$];
		int r;
		bit hexy;
		hexy = (sb.base_sel == BASE_HEX || sb.base_sel == BASE_AUTO);
		r = $urandom_range(0, 99);
		if (r < 80) begin
			if ($urandom_range(0, 2) == 0) begin
				s.push_back(CH_MINUS);
			end
			if (hexy && $urandom_range(0, 1) == 1) begin
				s.push_back(CH_ZERO);
				s.push_back(CH_X);
			end
			repeat ($urandom_range(0, ($urandom_range(0, 5) == 0) ? 24 : 8)) begin
				s.push_back(rand_digit(hexy || $urandom_range(0, 9) == 0));
			end
			// without a terminator the next first character restarts mid parse
			if (r < 70) begin
				s.push_back(($urandom_range(0, 1) == 1) ? CH_NUL : 8'($urandom_range(0, 255)));
			end
			foreach (s[i]) put(s[i], i == 0);
		end else begin
			repeat ($urandom_range(1, 6)) s.push_back(8'($urandom_range(0, 255)));
			foreach (s[i]) put(s[i], i == 0 || $urandom_range(0, 3) == 0);
		end
		n = s.size();
		// trailing characters without the first flag; ignored once the string has ended
		if ($urandom_range(0, 3) == 0) begin
			repeat ($urandom_range(1, 3)) put(8'($urandom_range(0, 255)), 1'b0);
		end
	endtask

	task automatic run_phase(input logic [4:0] b, input logic sgn, input int n_items,
			input bit hold);
		int sent;
		int got;
		set_mode(b, sgn);
		if (hold) begin
			hold_req = 1'b1;
		end
		sent = 0;
		while (sent < n_items) begin
			random_string(got);
			sent += got;
		end
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// reset config: auto base, signed
		send_text("0x1f");
		put(CH_NUL, 1'b0);
		send_text("0x");
		put(CH_NUL, 1'b0);
		send_text("5");
		send_text("7");
		put(CH_NUL, 1'b0);
		put("q", 1'b0);

		// hex, unsigned: minus refused, bare prefix, prefix with digits
		set_mode(BASE_HEX, 1'b0);
		send_text("-");
		send_text("0xG");
		send_text("0xAf");
		put(8'hFF, 1'b0);

		// a string open across a config write keeps the base it started with
		send_text("12");
		set_mode(BASE_MAX, 1'b1);
		put("a", 1'b0);
		put(CH_NUL, 1'b0);
		send_text("-90");
		put(CH_NUL, 1'b0);

		run_phase(BASE_AUTO, 1'b1, 200, 1'b0);
		run_phase(BASE_HEX, 1'b0, 200, 1'b0);
		run_phase(BASE_DEC, 1'b1, 200, 1'b1);
		run_phase(BASE_HEX, 1'b1, 200, 1'b0);
		run_phase(5'd1, 1'b0, 150, 1'b0);
		run_phase(BASE_MAX, 1'b1, 150, 1'b0);
		run_phase(5'd2, 1'b0, 150, 1'b0);
		run_phase(BASE_AUTO, 1'b0, 200, 1'b0);
		run_phase(5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)), 150, 1'b0);
		run_phase(5'd17, 1'b1, 100, 1'b0);

		// last part at full rate on both sides
		tx_gaps = 1'b0;
		rx_gaps = 1'b0;
		run_phase(BASE_AUTO, 1'b1, 200, 1'b0);

		settle();
		if (sb.errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
hw/rtl/aip_pkg.sv
hw/rtl/aip_core.sv
hw/rtl/aip_out.sv
hw/rtl/ascii_integer_parser.sv
sim/tb_ascii_integer_parser.sv
